/* rtl/tlik_pkg.sv */
// Package for the two-link inverse kinematics block: payload types, command
// and status structs, fixed-point widths, angle constants and the arctangent table.
// No dependencies.
`default_nettype none
package tlik_pkg;

  localparam int ANGLE_FRACTION_BITS = 13;
  localparam int CORDIC_ITERATIONS   = 16;

  localparam int CW        = 28;  // CORDIC x/y width
  localparam int ZW        = 36;  // Q2.30 angle accumulator width
  localparam int SQ_W      = 50;  // square-root operand width
  localparam int DV_W      = 40;  // divider operand width
  localparam int QW        = 24;  // quotient bits
  localparam int CV_W      = 26;  // signed Q1.24 cosine width
  localparam int NW        = 34;  // cosine numerator width
  localparam int OUT_SHIFT = 30 - ANGLE_FRACTION_BITS;

  localparam logic signed [ZW-1:0] PI_Q30      = 36'sd3373259426;
  localparam logic signed [ZW-1:0] HALF_PI_Q30 = 36'sd1686629713;
  localparam logic signed [CV_W-1:0] COS_ONE   = 26'sd16777216;

  typedef struct packed {
    logic signed [15:0] target_x;
    logic signed [15:0] target_y;
  } in_t;

  typedef struct packed {
    logic signed [15:0] shoulder_angle;
    logic signed [15:0] elbow_angle;
    logic               reachable;
  } out_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_SQUARE,
    OP_CHECK,
    OP_SQRT_B,
    OP_DEN,
    OP_DIV,
    OP_CSQ,
    OP_SQRT_C,
    OP_ACOS,
    OP_BASE,
    OP_FINISH
  } op_e;

  typedef struct packed {
    op_e  op;
    logic elbow;
  } cmd_t;

  typedef struct packed {
    logic busy;
    logic reach_ok;
    logic out_free;
  } stat_t;

  function automatic logic [31:0] atan_tab(input logic [4:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:  v = 32'h3243F6A8;
      5'd1:  v = 32'h1DAC6705;
      5'd2:  v = 32'h0FADBAFC;
      5'd3:  v = 32'h07F56EA6;
      5'd4:  v = 32'h03FEAB76;
      5'd5:  v = 32'h01FFD55B;
      5'd6:  v = 32'h00FFFAAA;
      5'd7:  v = 32'h007FFF55;
      5'd8:  v = 32'h003FFFEA;
      5'd9:  v = 32'h001FFFFD;
      5'd10: v = 32'h000FFFFF;
      5'd11: v = 32'h0007FFFF;
      5'd12: v = 32'h0003FFFF;
      5'd13: v = 32'h0001FFFF;
      5'd14: v = 32'h0000FFFF;
      5'd15: v = 32'h00007FFF;
      5'd16: v = 32'h00003FFF;
      5'd17: v = 32'h00001FFF;
      5'd18: v = 32'h00000FFF;
      5'd19: v = 32'h000007FF;
      5'd20: v = 32'h000003FF;
      5'd21: v = 32'h000001FF;
      5'd22: v = 32'h000000FF;
      5'd23: v = 32'h0000007F;
      5'd24: v = 32'h0000003F;
      5'd25: v = 32'h0000001F;
      5'd26: v = 32'h0000000F;
      5'd27: v = 32'h00000008;
      5'd28: v = 32'h00000004;
      5'd29: v = 32'h00000002;
      5'd30: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

/* rtl/tlik_cordic.sv */
// Iterative vectoring CORDIC: atan2(y, x) in Q2.30, one micro-rotation per cycle.
// Depends on tlik_pkg.
`default_nettype none
module tlik_cordic (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  input  wire logic signed [tlik_pkg::CW-1:0] y_i,
  input  wire logic signed [tlik_pkg::CW-1:0] x_i,
  output logic                              busy_o,
  output logic signed [tlik_pkg::ZW-1:0]    z_o
);
  import tlik_pkg::*;

  localparam int CNT_W = $clog2(CORDIC_ITERATIONS);

  logic                 busy_q;
  logic [CNT_W-1:0]     cnt_q;
  logic signed [CW-1:0] x_q, y_q;
  logic signed [ZW-1:0] z_q;
  logic signed [CW-1:0] dx, dy;
  logic signed [ZW-1:0] at;

  assign dx = y_q >>> cnt_q;
  assign dy = x_q >>> cnt_q;
  assign at = $signed(ZW'(atan_tab(5'(cnt_q))));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      if (cnt_q == CNT_W'(CORDIC_ITERATIONS - 1)) begin
        busy_q <= 1'b0;
      end else begin
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      if (x_i < 0) begin
        x_q <= y_i;
        y_q <= -x_i;
        z_q <= HALF_PI_Q30;
      end else begin
        x_q <= x_i;
        y_q <= y_i;
        z_q <= '0;
      end
    end else if (busy_q) begin
      if (!y_q[CW-1]) begin
        x_q <= x_q + dx;
        y_q <= y_q - dy;
        z_q <= z_q + at;
      end else begin
        x_q <= x_q - dx;
        y_q <= y_q + dy;
        z_q <= z_q - at;
      end
    end
  end

  assign busy_o = busy_q;
  assign z_o    = z_q;

endmodule
`default_nettype wire

/* rtl/tlik_datapath.sv */
// Datapath: squares, reach check, shared square root, divider and CORDIC,
// held angles and the output register. Depends on tlik_pkg and tlik_cordic.
`default_nettype none
module tlik_datapath (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire tlik_pkg::cmd_t cmd_i,
  input  wire tlik_pkg::in_t  in_data_i,
  input  wire logic [13:0]    l1_i,
  input  wire logic [13:0]    l2_i,
  input  wire logic           out_stall_i,
  output tlik_pkg::stat_t     stat_o,
  output logic                out_valid_o,
  output tlik_pkg::out_t      out_data_o
);
  import tlik_pkg::*;

  function automatic logic signed [15:0] to_out(input logic signed [ZW-1:0] a);
    logic signed [ZW-1:0] r;
    r = (a + $signed(ZW'(1) << (OUT_SHIFT - 1))) >>> OUT_SHIFT;
    if (r > 36'sd32767) begin
      return 16'sh7FFF;
    end else if (r < -36'sd32768) begin
      return 16'sh8000;
    end
    return r[15:0];
  endfunction

  logic signed [15:0] x_q, y_q;
  logic [31:0] xx_q, yy_q;
  logic [27:0] l1sq_q, l2sq_q, l12_q;
  logic [29:0] lsum_sq_q;
  logic [31:0] s_q;
  logic        ok_q;
  logic signed [NW-1:0] nsh_q, nel_q;

  logic [SQ_W-1:0] sq_n_q, sq_res_q, sq_bit_q;
  logic            sq_busy_q;
  logic [SQ_W-1:0] sq_trial;

  logic [DV_W-1:0] den_q, mag_q, rem_q;
  logic            neg_q;
  logic [QW-1:0]   quo_q;
  logic [4:0]      dv_cnt_q;
  logic            dv_busy_q;
  logic [DV_W:0]   rem2;
  logic            take;
  logic [QW-1:0]   quo_nx;
  logic signed [CV_W-1:0] cos_q;
  logic [SQ_W-1:0] csq_q;

  logic signed [ZW-1:0] acos_sh_q, acos_el_q, cz;
  logic                 cz_busy, cz_start;
  logic signed [CW-1:0] cy, cx;

  logic signed [15:0] held_sh_q, held_el_q;
  logic               out_valid_q;
  out_t               out_q;

  logic [31:0]           s_d;
  logic signed [NW-1:0]  nsh_d;
  logic [NW-1:0]         mag_sh, mag_el;
  logic [38:0]           l1bq;
  logic signed [2*CV_W-1:0] cprod;
  logic signed [ZW-1:0]  alpha, beta;
  logic signed [15:0]    new_sh, new_el;

  assign s_d   = xx_q + yy_q;
  assign nsh_d = $signed(NW'(l1sq_q)) - $signed(NW'(l2sq_q)) + $signed(NW'(s_d));
  assign mag_sh = nsh_q[NW-1] ? NW'(-nsh_q) : NW'(nsh_q);
  assign mag_el = nel_q[NW-1] ? NW'(-nel_q) : NW'(nel_q);
  assign l1bq   = 39'(l1_i) * 39'(sq_res_q[24:0]);
  assign cprod  = cos_q * cos_q;

  assign sq_trial = sq_res_q + sq_bit_q;
  assign rem2     = {rem_q, 1'b0};
  assign take     = (rem2 >= {1'b0, den_q});
  assign quo_nx   = {quo_q[QW-2:0], take};

  assign alpha  = cz - acos_sh_q;
  assign beta   = PI_Q30 - acos_el_q;
  assign new_sh = to_out(alpha);
  assign new_el = to_out(beta);

  assign cz_start = (cmd_i.op == OP_ACOS) || (cmd_i.op == OP_BASE);
  assign cy = (cmd_i.op == OP_BASE) ? (CW'(y_q) <<< 9) : $signed(CW'(sq_res_q[24:0]));
  assign cx = (cmd_i.op == OP_BASE) ? (CW'(x_q) <<< 9) : CW'(cos_q);

  tlik_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cz_start),
    .y_i     (cy),
    .x_i     (cx),
    .busy_o  (cz_busy),
    .z_o     (cz)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ok_q        <= 1'b0;
      sq_busy_q   <= 1'b0;
      dv_busy_q   <= 1'b0;
      dv_cnt_q    <= '0;
      held_sh_q   <= '0;
      held_el_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.op == OP_CHECK) begin
        ok_q <= (x_q > 0) && (y_q > 0) && (s_d < 32'(lsum_sq_q));
      end
      if ((cmd_i.op == OP_SQRT_B) || (cmd_i.op == OP_SQRT_C)) begin
        sq_busy_q <= 1'b1;
      end else if (sq_busy_q && (sq_bit_q == SQ_W'(1))) begin
        sq_busy_q <= 1'b0;
      end
      if ((cmd_i.op == OP_DIV) && (mag_q < den_q)) begin
        dv_busy_q <= 1'b1;
        dv_cnt_q  <= '0;
      end else if (dv_busy_q) begin
        if (dv_cnt_q == 5'(QW - 1)) begin
          dv_busy_q <= 1'b0;
        end else begin
          dv_cnt_q <= dv_cnt_q + 1'b1;
        end
      end
      if ((cmd_i.op == OP_FINISH) && ok_q) begin
        held_sh_q <= new_sh;
        held_el_q <= new_el;
      end
      if (cmd_i.op == OP_FINISH) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        x_q <= in_data_i.target_x;
        y_q <= in_data_i.target_y;
      end
      OP_SQUARE: begin
        xx_q      <= 32'(x_q * x_q);
        yy_q      <= 32'(y_q * y_q);
        l1sq_q    <= 28'(l1_i) * 28'(l1_i);
        l2sq_q    <= 28'(l2_i) * 28'(l2_i);
        l12_q     <= 28'(l1_i) * 28'(l2_i);
        lsum_sq_q <= 30'(15'(l1_i) + 15'(l2_i)) * 30'(15'(l1_i) + 15'(l2_i));
      end
      OP_CHECK: begin
        s_q   <= s_d;
        nsh_q <= nsh_d;
      end
      OP_DEN: begin
        if (!cmd_i.elbow) begin
          den_q <= {l1bq, 1'b0};
          mag_q <= DV_W'(mag_sh) << 8;
          neg_q <= nsh_q[NW-1];
        end else begin
          den_q     <= DV_W'({l12_q, 1'b0});
          mag_q     <= DV_W'(mag_el);
          neg_q     <= nel_q[NW-1];
          acos_sh_q <= cz;
        end
      end
      OP_CSQ: csq_q <= SQ_W'(cprod);
      OP_BASE: acos_el_q <= cz;
      default: ;
    endcase
    if (cmd_i.op == OP_SQUARE) begin
      nel_q <= nel_q;
    end else if (cmd_i.op == OP_CHECK) begin
      nel_q <= $signed(NW'(l1sq_q)) + $signed(NW'(l2sq_q)) - $signed(NW'(s_d));
    end
    if (cmd_i.op == OP_SQRT_B) begin
      sq_n_q   <= SQ_W'({s_q, 16'b0});
      sq_res_q <= '0;
      sq_bit_q <= SQ_W'(1) << 48;
    end else if (cmd_i.op == OP_SQRT_C) begin
      sq_n_q   <= (SQ_W'(1) << 48) - csq_q;
      sq_res_q <= '0;
      sq_bit_q <= SQ_W'(1) << 48;
    end else if (sq_busy_q) begin
      if (sq_n_q >= sq_trial) begin
        sq_n_q   <= sq_n_q - sq_trial;
        sq_res_q <= (sq_res_q >> 1) + sq_bit_q;
      end else begin
        sq_res_q <= sq_res_q >> 1;
      end
      sq_bit_q <= sq_bit_q >> 2;
    end
    if (cmd_i.op == OP_DIV) begin
      rem_q <= mag_q;
      quo_q <= '0;
      if (mag_q >= den_q) begin
        cos_q <= neg_q ? -COS_ONE : COS_ONE;
      end
    end else if (dv_busy_q) begin
      rem_q <= take ? DV_W'(rem2 - {1'b0, den_q}) : DV_W'(rem2);
      quo_q <= quo_nx;
      if (dv_cnt_q == 5'(QW - 1)) begin
        cos_q <= neg_q ? -$signed(CV_W'(quo_nx)) : $signed(CV_W'(quo_nx));
      end
    end
    if (cmd_i.op == OP_FINISH) begin
      out_q.shoulder_angle <= ok_q ? new_sh : held_sh_q;
      out_q.elbow_angle    <= ok_q ? new_el : held_el_q;
      out_q.reachable      <= ok_q;
    end
  end

  assign stat_o.busy     = sq_busy_q | dv_busy_q | cz_busy;
  assign stat_o.reach_ok = ok_q;
  assign stat_o.out_free = !out_valid_q || !out_stall_i;
  assign out_valid_o     = out_valid_q;
  assign out_data_o      = out_q;

endmodule
`default_nettype wire

/* rtl/tlik_ctrl.sv */
// Controller: sequences the datapath steps for one target and handles the input
// handshake. Depends on tlik_pkg.
`default_nettype none
module tlik_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_stall_o,
  input  wire tlik_pkg::stat_t stat_i,
  output tlik_pkg::cmd_t       cmd_o
);
  import tlik_pkg::*;

  typedef enum logic [11:0] {
    ST_IDLE   = 12'b000000000001,
    ST_SQUARE = 12'b000000000010,
    ST_CHECK  = 12'b000000000100,
    ST_DECIDE = 12'b000000001000,
    ST_SQRT_B = 12'b000000010000,
    ST_DEN    = 12'b000000100000,
    ST_DIV    = 12'b000001000000,
    ST_CSQ    = 12'b000010000000,
    ST_SQRT_C = 12'b000100000000,
    ST_ACOS   = 12'b001000000000,
    ST_BASE   = 12'b010000000000,
    ST_FINISH = 12'b100000000000
  } state_e;

  state_e state_q, state_d;
  logic   launched_q, launched_d;
  logic   elbow_q, elbow_d;

  always_comb begin
    state_d     = state_q;
    launched_d  = launched_q;
    elbow_d     = elbow_q;
    cmd_o.op    = OP_NONE;
    cmd_o.elbow = elbow_q;
    in_stall_o  = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          state_d  = ST_SQUARE;
        end
      end
      ST_SQUARE: begin
        cmd_o.op = OP_SQUARE;
        state_d  = ST_CHECK;
      end
      ST_CHECK: begin
        cmd_o.op = OP_CHECK;
        state_d  = ST_DECIDE;
      end
      ST_DECIDE: begin
        elbow_d = 1'b0;
        state_d = stat_i.reach_ok ? ST_SQRT_B : ST_FINISH;
      end
      ST_SQRT_B: begin
        if (!launched_q) begin
          cmd_o.op   = OP_SQRT_B;
          launched_d = 1'b1;
        end else if (!stat_i.busy) begin
          launched_d = 1'b0;
          state_d    = ST_DEN;
        end
      end
      ST_DEN: begin
        cmd_o.op = OP_DEN;
        state_d  = ST_DIV;
      end
      ST_DIV: begin
        if (!launched_q) begin
          cmd_o.op   = OP_DIV;
          launched_d = 1'b1;
        end else if (!stat_i.busy) begin
          launched_d = 1'b0;
          state_d    = ST_CSQ;
        end
      end
      ST_CSQ: begin
        cmd_o.op = OP_CSQ;
        state_d  = ST_SQRT_C;
      end
      ST_SQRT_C: begin
        if (!launched_q) begin
          cmd_o.op   = OP_SQRT_C;
          launched_d = 1'b1;
        end else if (!stat_i.busy) begin
          launched_d = 1'b0;
          state_d    = ST_ACOS;
        end
      end
      ST_ACOS: begin
        if (!launched_q) begin
          cmd_o.op   = OP_ACOS;
          launched_d = 1'b1;
        end else if (!stat_i.busy) begin
          launched_d = 1'b0;
          if (elbow_q) begin
            state_d = ST_BASE;
          end else begin
            elbow_d = 1'b1;
            state_d = ST_DEN;
          end
        end
      end
      ST_BASE: begin
        if (!launched_q) begin
          cmd_o.op   = OP_BASE;
          launched_d = 1'b1;
        end else if (!stat_i.busy) begin
          launched_d = 1'b0;
          state_d    = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (stat_i.out_free) begin
          cmd_o.op = OP_FINISH;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d    = ST_IDLE;
        launched_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      launched_q <= 1'b0;
      elbow_q    <= 1'b0;
    end else begin
      state_q    <= state_d;
      launched_q <= launched_d;
      elbow_q    <= elbow_d;
    end
  end

endmodule
`default_nettype wire

/* rtl/two_link_inverse_kinematics.sv */
// Two-link planar inverse kinematics top level: APB link-length registers,
// controller and datapath. Depends on tlik_pkg, tlik_ctrl and tlik_datapath.
//
// Takes one target (x, y) at a time and returns the shoulder and elbow angles in
// signed Q2.13 radians. A target outside the first quadrant or out of reach
// returns the previous angles with reachable low. For a reachable target one
// shared bit-serial square root (run three times), one restoring divider (run
// twice) and one 16-step CORDIC (run three times) work in sequence; a cosine that
// clamps to +1 or -1 skips its divide. The next target is taken once the result
// sits in the output register; a stalled output that still holds the previous
// result delays that.
`default_nettype none
module two_link_inverse_kinematics (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_stall_o,
  input  wire tlik_pkg::in_t  in_data_i,
  output logic                out_valid_o,
  input  wire logic           out_stall_i,
  output tlik_pkg::out_t      out_data_o,
  input  wire logic           psel,
  input  wire logic           penable,
  input  wire logic           pwrite,
  input  wire logic [2:0]     paddr,
  input  wire logic [31:0]    pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import tlik_pkg::*;

  localparam logic REG_UPPER = 1'b0;
  localparam logic REG_LOWER = 1'b1;

  logic [13:0] l1_q, l2_q;
  logic        wr_en;
  cmd_t        cmd;
  stat_t       stat;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      l1_q <= 14'd300;
      l2_q <= 14'd300;
    end else if (wr_en) begin
      case (paddr[2])
        REG_UPPER: l1_q <= pwdata[13:0];
        REG_LOWER: l2_q <= pwdata[13:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[1:0] == 2'b00) begin
      case (paddr[2])
        REG_UPPER: prdata = 32'(l1_q);
        REG_LOWER: prdata = 32'(l2_q);
        default:   prdata = '0;
      endcase
    end
  end

  tlik_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  tlik_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .in_data_i   (in_data_i),
    .l1_i        (l1_q),
    .l2_i        (l2_q),
    .out_stall_i (out_stall_i),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule
`default_nettype wire
